// File: rtl/cda_pkg.sv
// shared types and codes for the call descriptor allocator
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned DESC_W   = 7;
  localparam int unsigned CORR_W   = 64;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RES_PLAIN = 3'd0,
    KIND_RES_CORR  = 3'd1,
    KIND_UNRESERVE = 3'd2,
    KIND_QUERY     = 3'd3,
    KIND_GET_DESC  = 3'd4,
    KIND_GET_CORR  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_CORR = 2'd3
  } status_e;

  // control part of the request token that walks the cell chain
  typedef struct packed {
    logic  vld;
    kind_e kind;
    logic  hit;
    logic  good;
    logic  act;
    logic  idle;
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: rtl/call_descriptor_allocator.sv
// top level of the call descriptor allocator: cell chain, request intake, result register
//
// usage:
//   requests arrive on the s_axis channel, one transfer per request; the kind code
//   travels in s_axis_tuser, descriptor and correlation key in s_axis_tdata
//   each request walks a chain of MAX_ENTRIES cells, one cell per cycle unless held;
//   every cell holds one table entry and applies the request to itself as it passes
//   results leave on the m_axis channel, one transfer per request, in order
//   one request is in flight in the cell chain at a time, so the walk through the
//   chain sets how often new requests are taken
//   s_axis_tready drops while a request walks the chain and rises again once its
//   result sits in the output register, so a new request is taken while that
//   result still waits for the receiver
//   if the receiver stalls and a second result reaches the chain end, the chain
//   holds until the output register frees up
//   reset: all entries inactive with key zero, the first INITIAL_ENTRIES entries
//   exist, no request in flight, output empty
`timescale 1ns / 1ps
`default_nettype none

module call_descriptor_allocator #(
  parameter int unsigned MAX_ENTRIES     = 64,
  parameter int unsigned INITIAL_ENTRIES = 8,
  parameter int unsigned KEY_WIDTH       = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // descriptor[6:0], correlation[70:7], zero pad
  input  wire logic [7:0]  s_axis_tuser,  // kind[2:0], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata   // status[1:0], result_descriptor[8:2],
                                          // result_correlation[72:9], is_active[73],
                                          // all_idle[74], zero pad
);

  localparam int unsigned DW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (DW > cda_pkg::DESC_W) ? DW : cda_pkg::DESC_W;

  cda_pkg::tok_ctl_t          chain_ctl   [MAX_ENTRIES+1];
  logic [cda_pkg::DESC_W-1:0] chain_desc  [MAX_ENTRIES+1];
  logic [KEY_WIDTH-1:0]       chain_key   [MAX_ENTRIES+1];
  logic [CW-1:0]              chain_rdesc [MAX_ENTRIES+1];
  logic [KEY_WIDTH-1:0]       chain_rcorr [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0]     tok_vld;

  logic busy_q, busy_d;
  logic out_vld_q, out_vld_d;
  logic in_xfer, load, chain_en;

  cda_pkg::status_e            status_q, status_d;
  logic [cda_pkg::DESC_W-1:0]  rdesc_q;
  logic [cda_pkg::CORR_W-1:0]  rcorr_q;
  logic                        act_q;
  logic                        idle_q;

  cda_pkg::tok_ctl_t tail;

  assign s_axis_tready = !busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign tail          = chain_ctl[MAX_ENTRIES];
  assign load          = tail.vld && (!out_vld_q || m_axis_tready);
  assign chain_en      = !(tail.vld && !load);

  assign chain_ctl[0] = '{
    vld:  in_xfer,
    kind: cda_pkg::kind_e'(s_axis_tuser[cda_pkg::KIND_W-1:0]),
    hit:  1'b0,
    good: 1'b0,
    act:  1'b0,
    idle: 1'b1
  };

  assign chain_desc[0]  = s_axis_tdata[cda_pkg::DESC_W-1:0];
  assign chain_key[0]   = s_axis_tdata[cda_pkg::DESC_W +: KEY_WIDTH];
  assign chain_rdesc[0] = '0;
  assign chain_rcorr[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cda_cell #(
      .IDX        (i),
      .KEY_WIDTH  (KEY_WIDTH),
      .CW         (CW),
      .EXISTS_RST (i < INITIAL_ENTRIES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .ctl_i   (chain_ctl[i]),
      .desc_i  (chain_desc[i]),
      .key_i   (chain_key[i]),
      .rdesc_i (chain_rdesc[i]),
      .rcorr_i (chain_rcorr[i]),
      .ctl_o   (chain_ctl[i+1]),
      .desc_o  (chain_desc[i+1]),
      .key_o   (chain_key[i+1]),
      .rdesc_o (chain_rdesc[i+1]),
      .rcorr_o (chain_rcorr[i+1])
    );
    assign tok_vld[i] = chain_ctl[i+1].vld;
  end

  always_comb begin
    case (tail.kind)
      cda_pkg::KIND_RES_PLAIN, cda_pkg::KIND_RES_CORR:
        status_d = tail.good ? cda_pkg::ST_OK : cda_pkg::ST_FULL;
      cda_pkg::KIND_UNRESERVE, cda_pkg::KIND_QUERY, cda_pkg::KIND_GET_DESC:
        status_d = tail.good ? cda_pkg::ST_OK : cda_pkg::ST_BAD;
      cda_pkg::KIND_GET_CORR:
        status_d = tail.good ? cda_pkg::ST_OK : cda_pkg::ST_NO_CORR;
      default:
        status_d = cda_pkg::ST_BAD;
    endcase
  end

  always_comb begin
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
      busy_d    = 1'b0;
    end
    if (in_xfer) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      rdesc_q  <= chain_rdesc[MAX_ENTRIES][cda_pkg::DESC_W-1:0];
      rcorr_q  <= cda_pkg::CORR_W'(chain_rcorr[MAX_ENTRIES]);
      act_q    <= tail.act;
      idle_q   <= tail.idle;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, idle_q, act_q, rcorr_q, rdesc_q, status_q};

  // at most one request walks the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one request in the cell chain");

  // a token in the chain always belongs to an accepted request
  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vld != '0) |-> busy_q)
    else $error("request token without an accepted request");

  // a finished walk lands in the output register and frees the input side
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (m_axis_tvalid && !busy_q))
    else $error("result not delivered to the output register");

  // no new request is taken while one is in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vld != '0) |-> !in_xfer)
    else $error("request accepted during a chain walk");

endmodule

`default_nettype wire

// File: rtl/cda_cell.sv
// one table entry of the allocator chain, updated as the request token passes
`timescale 1ns / 1ps
`default_nettype none

module cda_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned KEY_WIDTH  = 64,
  parameter int unsigned CW         = 7,
  parameter bit          EXISTS_RST = 1'b0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire cda_pkg::tok_ctl_t            ctl_i,
  input  wire logic [cda_pkg::DESC_W-1:0]   desc_i,
  input  wire logic [KEY_WIDTH-1:0]         key_i,
  input  wire logic [CW-1:0]                rdesc_i,
  input  wire logic [KEY_WIDTH-1:0]         rcorr_i,
  output cda_pkg::tok_ctl_t                 ctl_o,
  output logic [cda_pkg::DESC_W-1:0]        desc_o,
  output logic [KEY_WIDTH-1:0]              key_o,
  output logic [CW-1:0]                     rdesc_o,
  output logic [KEY_WIDTH-1:0]              rcorr_o
);

  localparam logic [CW-1:0] MY_DESC = CW'(IDX + 1);

  logic                 exists_q, exists_d;
  logic                 active_q, active_d;
  logic [KEY_WIDTH-1:0] entry_key_q, entry_key_d;

  cda_pkg::tok_ctl_t    ctl_q, ctl_d;
  logic [cda_pkg::DESC_W-1:0] tdesc_q;
  logic [KEY_WIDTH-1:0] tkey_q;
  logic [CW-1:0]        rdesc_q, rdesc_d;
  logic [KEY_WIDTH-1:0] rcorr_q, rcorr_d;

  logic dmatch;

  assign dmatch = exists_q && (CW'(desc_i) == MY_DESC);

  always_comb begin
    exists_d    = exists_q;
    active_d    = active_q;
    entry_key_d = entry_key_q;
    ctl_d       = ctl_i;
    rdesc_d     = rdesc_i;
    rcorr_d     = rcorr_i;
    if (ctl_i.vld) begin
      case (ctl_i.kind)
        cda_pkg::KIND_RES_PLAIN, cda_pkg::KIND_RES_CORR: begin
          if (!ctl_i.hit && !(exists_q && active_q)) begin
            exists_d = 1'b1;
            active_d = 1'b1;
            if (ctl_i.kind == cda_pkg::KIND_RES_CORR) begin
              entry_key_d = key_i;
            end else if (!exists_q) begin
              entry_key_d = '0;
            end
            ctl_d.hit  = 1'b1;
            ctl_d.good = 1'b1;
            rdesc_d    = MY_DESC;
            rcorr_d    = entry_key_d;
          end
        end
        cda_pkg::KIND_UNRESERVE: begin
          if (dmatch) begin
            active_d   = 1'b0;
            ctl_d.good = 1'b1;
            rdesc_d    = MY_DESC;
            rcorr_d    = entry_key_q;
          end
        end
        cda_pkg::KIND_QUERY: begin
          if (dmatch) begin
            ctl_d.good = 1'b1;
            ctl_d.act  = active_q;
            rdesc_d    = MY_DESC;
            rcorr_d    = entry_key_q;
          end
        end
        cda_pkg::KIND_GET_DESC: begin
          if (dmatch && active_q) begin
            ctl_d.good = 1'b1;
            rdesc_d    = MY_DESC;
            rcorr_d    = entry_key_q;
          end
        end
        cda_pkg::KIND_GET_CORR: begin
          // first existing key match decides, active or not
          if (!ctl_i.hit && exists_q && (entry_key_q == key_i)) begin
            ctl_d.hit = 1'b1;
            if (active_q) begin
              ctl_d.good = 1'b1;
              rdesc_d    = MY_DESC;
              rcorr_d    = entry_key_q;
            end
          end
        end
        default: begin
        end
      endcase
      ctl_d.idle = ctl_i.idle && !(exists_d && active_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q    <= EXISTS_RST;
      active_q    <= 1'b0;
      entry_key_q <= '0;
      ctl_q       <= '0;
    end else if (en_i) begin
      exists_q    <= exists_d;
      active_q    <= active_d;
      entry_key_q <= entry_key_d;
      ctl_q       <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tdesc_q <= desc_i;
      tkey_q  <= key_i;
      rdesc_q <= rdesc_d;
      rcorr_q <= rcorr_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign desc_o  = tdesc_q;
  assign key_o   = tkey_q;
  assign rdesc_o = rdesc_q;
  assign rcorr_o = rcorr_q;

endmodule

`default_nettype wire
